### hw/rtl/kplc_pkg.sv
package kplc_pkg;

    localparam int DEFAULT_PIN_DIGITS = 4;

    localparam int TIMER_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int KEY_W = 8;
    localparam int DIGITS_OUT_W = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRANTED = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_STORED_PIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_TIMEOUT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCESS_TIME   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RED_BLINK     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_FLASH     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BUZZER        = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_STORED_PIN   = 32'd825373492;
    localparam logic [TIMER_W-1:0]    RST_INPUT_TIMEOUT = 16'd10000;
    localparam logic [TIMER_W-1:0]    RST_ACCESS_TIME   = 16'd3000;
    localparam logic [TIMER_W-1:0]    RST_RED_BLINK     = 16'd500;
    localparam logic [TIMER_W-1:0]    RST_KEY_FLASH     = 16'd100;
    localparam logic [TIMER_W-1:0]    RST_BUZZER        = 16'd300;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
        logic [TIMER_W-1:0] r;
        if (v == TIMER_MAX)
        begin
            r = v;
        end
        else
        begin
            r = v + TIMER_W'(1);
        end
        return r;
    endfunction

endpackage

### hw/rtl/keypad_pin_lock_controller.sv
// an input transfer reaches its result through the input register, then the result register
// throughput: one tick item per cycle unless m_axis_tready stalls the output; an empty input
// register takes a new item while a result waits; one result transfer per input transfer, in order
// reset: asynchronous, active low; mode idle, red on, green off, lock closed, counters cleared,
// configuration registers back to their defaults
module keypad_pin_lock_controller
    import kplc_pkg::*;
#(
    parameter int PIN_DIGITS = DEFAULT_PIN_DIGITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [KEY_W-1:0]        s_axis_tdata,   // key_code
    input  logic [1:0]              s_axis_tuser,   // key_valid, badge_ok

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // mode[1:0], red_led, green_led, buzzer_on, lock_open, wrong_pin, digits_entered[2:0], zero pad
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(PIN_DIGITS + 1);
    localparam int IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);
    localparam int PAD_W = OUT_TDATA_W - MODE_W - 5 - DIGITS_OUT_W;

    // configuration
    logic [CFG_DATA_W-1:0] stored_pin_reg;
    logic [TIMER_W-1:0]    input_timeout_reg;
    logic [TIMER_W-1:0]    access_time_reg;
    logic [TIMER_W-1:0]    red_blink_reg;
    logic [TIMER_W-1:0]    key_flash_reg;
    logic [TIMER_W-1:0]    buzzer_reg;

    // input register
    logic              in_valid_reg;
    logic              key_valid_reg;
    logic [KEY_W-1:0]  key_code_reg;
    logic              badge_reg;

    // controller state
    logic [MODE_W-1:0]  mode_reg,          mode_next;
    logic [KEY_W-1:0]   pin_digits_reg [PIN_DIGITS];
    logic [CNT_W-1:0]   digit_count_reg,   digit_count_next;
    logic [TIMER_W-1:0] mode_elapsed_reg,  mode_elapsed_next;
    logic [TIMER_W-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic [TIMER_W-1:0] flash_elapsed_reg, flash_elapsed_next;
    logic               flash_active_reg,  flash_active_next;
    logic [TIMER_W-1:0] buzz_elapsed_reg,  buzz_elapsed_next;
    logic               buzz_active_reg,   buzz_active_next;
    logic               red_reg,           red_next;
    logic               green_reg,         green_next;
    logic               lock_reg,          lock_next;
    logic               wrong_reg,         wrong_next;
    logic               out_valid_reg;

    logic              advance;
    logic              pin_wr_en;
    logic [IDX_W-1:0]  pin_wr_idx;
    logic [PIN_DIGITS-1:0] digit_ok;
    logic              pin_ok;
    logic              go;
    logic [MODE_W-1:0] go_target;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_pin_reg    <= RST_STORED_PIN;
            input_timeout_reg <= RST_INPUT_TIMEOUT;
            access_time_reg   <= RST_ACCESS_TIME;
            red_blink_reg     <= RST_RED_BLINK;
            key_flash_reg     <= RST_KEY_FLASH;
            buzzer_reg        <= RST_BUZZER;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_STORED_PIN:    stored_pin_reg    <= cfg_data;
                CFG_INPUT_TIMEOUT: input_timeout_reg <= cfg_data[TIMER_W-1:0];
                CFG_ACCESS_TIME:   access_time_reg   <= cfg_data[TIMER_W-1:0];
                CFG_RED_BLINK:     red_blink_reg     <= cfg_data[TIMER_W-1:0];
                CFG_KEY_FLASH:     key_flash_reg     <= cfg_data[TIMER_W-1:0];
                CFG_BUZZER:        buzzer_reg        <= cfg_data[TIMER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            key_valid_reg <= s_axis_tuser[0];
            badge_reg     <= s_axis_tuser[1];
            key_code_reg  <= s_axis_tdata;
        end
    end

    // pin compare: earlier digits from storage, the last one straight from the key
    genvar g;
    generate
        for (g = 0; g < PIN_DIGITS; g++)
        begin : g_digit
            localparam int POS = PIN_DIGITS - 1 - g;
            logic [KEY_W-1:0] want;
            if (POS < 4)
            begin : g_byte
                assign want = stored_pin_reg[KEY_W*POS +: KEY_W];
            end
            else
            begin : g_zero
                assign want = '0;
            end
            if (g == PIN_DIGITS - 1)
            begin : g_last
                assign digit_ok[g] = (key_code_reg == want);
            end
            else
            begin : g_prev
                assign digit_ok[g] = (pin_digits_reg[g] == want);
            end
        end
    endgenerate

    assign pin_ok = &digit_ok;

    always_comb
    begin
        mode_next          = mode_reg;
        digit_count_next   = digit_count_reg;
        mode_elapsed_next  = sat_inc(mode_elapsed_reg);
        blink_elapsed_next = sat_inc(blink_elapsed_reg);
        flash_elapsed_next = sat_inc(flash_elapsed_reg);
        buzz_elapsed_next  = sat_inc(buzz_elapsed_reg);
        flash_active_next  = flash_active_reg;
        buzz_active_next   = buzz_active_reg;
        red_next           = red_reg;
        green_next         = green_reg;
        lock_next          = lock_reg;
        wrong_next         = 1'b0;
        pin_wr_en          = 1'b0;
        pin_wr_idx         = digit_count_reg[IDX_W-1:0];
        go                 = 1'b0;
        go_target          = MODE_IDLE;

        case (mode_reg)
            MODE_IDLE:
            begin
                go = 1'b1;
                if (badge_reg)
                begin
                    go_target = MODE_GRANTED;
                end
                else
                begin
                    if (buzz_active_reg && buzz_elapsed_next >= buzzer_reg)
                    begin
                        buzz_active_next = 1'b0;
                    end
                    go_target = MODE_INPUT;
                end
            end
            MODE_INPUT:
            begin
                if (badge_reg)
                begin
                    go        = 1'b1;
                    go_target = MODE_GRANTED;
                end
                else
                begin
                    if (buzz_active_reg && buzz_elapsed_next >= buzzer_reg)
                    begin
                        buzz_active_next = 1'b0;
                    end
                    if (flash_active_reg)
                    begin
                        if (flash_elapsed_next >= key_flash_reg)
                        begin
                            green_next         = 1'b0;
                            flash_active_next  = 1'b0;
                            blink_elapsed_next = '0;
                        end
                    end
                    else if (blink_elapsed_next >= red_blink_reg)
                    begin
                        red_next           = !red_reg;
                        blink_elapsed_next = '0;
                    end
                    if (mode_elapsed_next >= input_timeout_reg)
                    begin
                        go        = 1'b1;
                        go_target = MODE_IDLE;
                    end
                    else if (key_valid_reg)
                    begin
                        red_next           = 1'b1;
                        green_next         = 1'b1;
                        flash_elapsed_next = '0;
                        flash_active_next  = 1'b1;
                        if (digit_count_reg < CNT_FULL)
                        begin
                            pin_wr_en        = 1'b1;
                            digit_count_next = digit_count_reg + CNT_W'(1);
                        end
                        if (digit_count_next == CNT_FULL)
                        begin
                            go = 1'b1;
                            if (pin_ok)
                            begin
                                go_target = MODE_GRANTED;
                            end
                            else
                            begin
                                wrong_next        = 1'b1;
                                buzz_elapsed_next = '0;
                                buzz_active_next  = 1'b1;
                                go_target         = MODE_IDLE;
                            end
                        end
                    end
                end
            end
            MODE_GRANTED:
            begin
                if (mode_elapsed_next >= access_time_reg)
                begin
                    go        = 1'b1;
                    go_target = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // mode entry
        if (go)
        begin
            mode_next         = go_target;
            mode_elapsed_next = '0;
            flash_active_next = 1'b0;
            case (go_target)
                MODE_IDLE:
                begin
                    digit_count_next = '0;
                    red_next         = 1'b1;
                    green_next       = 1'b0;
                    lock_next        = 1'b0;
                end
                MODE_INPUT:
                begin
                    blink_elapsed_next = '0;
                    red_next           = 1'b1;
                    green_next         = 1'b0;
                end
                MODE_GRANTED:
                begin
                    buzz_active_next = 1'b0;
                    red_next         = 1'b0;
                    green_next       = 1'b1;
                    lock_next        = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            digit_count_reg   <= '0;
            mode_elapsed_reg  <= '0;
            blink_elapsed_reg <= '0;
            flash_elapsed_reg <= '0;
            flash_active_reg  <= 1'b0;
            buzz_elapsed_reg  <= '0;
            buzz_active_reg   <= 1'b0;
            red_reg           <= 1'b1;
            green_reg         <= 1'b0;
            lock_reg          <= 1'b0;
            wrong_reg         <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            digit_count_reg   <= digit_count_next;
            mode_elapsed_reg  <= mode_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            flash_elapsed_reg <= flash_elapsed_next;
            flash_active_reg  <= flash_active_next;
            buzz_elapsed_reg  <= buzz_elapsed_next;
            buzz_active_reg   <= buzz_active_next;
            red_reg           <= red_next;
            green_reg         <= green_next;
            lock_reg          <= lock_next;
            wrong_reg         <= wrong_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pin_wr_en)
        begin
            pin_digits_reg[pin_wr_idx] <= key_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {PAD_W{1'b0}},
        DIGITS_OUT_W'(digit_count_reg),
        wrong_reg,
        lock_reg,
        buzz_active_reg,
        green_reg,
        red_reg,
        mode_reg
    };

    // checks
    a_lock_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg == (mode_reg == MODE_GRANTED))
        else $error("lock state disagrees with mode");

    a_wrong_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wrong_reg |-> (mode_reg == MODE_IDLE) && buzz_active_reg && (digit_count_reg == '0))
        else $error("wrong pin without idle mode and buzzer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= CNT_FULL)
        else $error("digit count beyond pin length");

    a_result_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule
